// ===== rtl/qmix_pkg.sv =====
// types, constants and helper functions shared by the quad mixer
package qmix_pkg;

   localparam int STICK_W = 12;
   localparam int ECHO_W  = 15;
   localparam int DUTY_W  = 16;
   localparam int CM_W    = 9;
   localparam int SPAN_W  = 10;
   localparam int MASK_W  = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] ECHO_TIMEOUT_DEFAULT = 16'd30000;

   localparam logic [11:0] STICK_FULL = 12'd4095;
   localparam logic [5:0]  US_PER_CM  = 6'd58;
   localparam logic [8:0]  NO_ECHO_CM = 9'd300;

   localparam logic [CM_W-1:0]   OBSTACLE_CM_RST   = 9'd30;
   localparam logic [DUTY_W-1:0] DUTY_MIN_RST      = 16'd3000;
   localparam logic [DUTY_W-1:0] DUTY_MAX_RST      = 16'd7000;
   localparam logic [SPAN_W-1:0] ATTITUDE_SPAN_RST = 10'd200;
   localparam logic [SPAN_W-1:0] AVOID_YAW_RST     = 10'd100;

   localparam int MASK_FRONT = 0;
   localparam int MASK_LEFT  = 1;
   localparam int MASK_RIGHT = 2;

   typedef enum logic [2:0] {
      REG_OBSTACLE_CM   = 3'd0,
      REG_DUTY_MIN      = 3'd1,
      REG_DUTY_MAX      = 3'd2,
      REG_ATTITUDE_SPAN = 3'd3,
      REG_AVOID_YAW     = 3'd4
   } reg_idx_type;

   // register values plus terms derived from them once per write
   typedef struct packed {
      logic [CM_W-1:0]   obstacle_cm;
      logic [DUTY_W-1:0] duty_min;
      logic [DUTY_W-1:0] duty_max;
      logic [SPAN_W-1:0] attitude_span;
      logic [SPAN_W-1:0] avoid_yaw;
      logic [4:0]        thr_quot;
      logic [11:0]       thr_rem;
      logic              thr_neg;
      logic [ECHO_W-1:0] thresh_us;
      logic              far_hit;
   } cfg_type;

   typedef struct packed {
      logic [ECHO_W-1:0]  echo_right_us;
      logic [ECHO_W-1:0]  echo_left_us;
      logic [ECHO_W-1:0]  echo_front_us;
      logic [STICK_W-1:0] stick_yaw;
      logic [STICK_W-1:0] stick_throttle;
      logic [STICK_W-1:0] stick_pitch;
      logic [STICK_W-1:0] stick_roll;
   } req_type;

   typedef struct packed {
      logic [22:0]       roll_prod;
      logic [22:0]       pitch_prod;
      logic [22:0]       yaw_prod;
      logic [16:0]       thr_hi;
      logic [23:0]       thr_lo;
      logic [MASK_W-1:0] mask;
   } prod_type;

   typedef struct packed {
      logic [MASK_W-1:0] override_mask;
      logic [DUTY_W-1:0] duty_motor3;
      logic [DUTY_W-1:0] duty_motor2;
      logic [DUTY_W-1:0] duty_motor1;
      logic [DUTY_W-1:0] duty_motor0;
   } rsp_type;

   // floor(n / 4095), exact for n below 4095*4096
   function automatic logic [11:0] div4095(input logic [23:0] n);
      logic [24:0] s;
      s = {1'b0, n} + 25'(n >> 12) + 25'd1;
      return s[23:12];
   endfunction

endpackage

// ===== rtl/qmix_csr.sv =====
// configuration registers with derived throttle and echo terms
module qmix_csr
   import qmix_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CM_W-1:0]   obstacle_cm_ff, obstacle_cm_in;
   logic [DUTY_W-1:0] duty_min_ff, duty_min_in;
   logic [DUTY_W-1:0] duty_max_ff, duty_max_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [SPAN_W-1:0] avoid_yaw_ff, avoid_yaw_in;
   logic [4:0]        thr_quot_ff, thr_quot_in;
   logic [11:0]       thr_rem_ff, thr_rem_in;
   logic              thr_neg_ff, thr_neg_in;
   logic [ECHO_W-1:0] thresh_us_ff, thresh_us_in;
   logic              far_hit_ff, far_hit_in;

   logic              wr;
   reg_idx_type       idx;
   logic [DUTY_W-1:0] diff_abs;
   logic [11:0]       quot_full;

   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      obstacle_cm_in = obstacle_cm_ff;
      duty_min_in    = duty_min_ff;
      duty_max_in    = duty_max_ff;
      span_in        = span_ff;
      avoid_yaw_in   = avoid_yaw_ff;
      if (reset) begin
         obstacle_cm_in = OBSTACLE_CM_RST;
         duty_min_in    = DUTY_MIN_RST;
         duty_max_in    = DUTY_MAX_RST;
         span_in        = ATTITUDE_SPAN_RST;
         avoid_yaw_in   = AVOID_YAW_RST;
      end else if (wr) begin
         case (idx)
            REG_OBSTACLE_CM:   obstacle_cm_in = csr_pwdata[CM_W-1:0];
            REG_DUTY_MIN:      duty_min_in    = csr_pwdata[DUTY_W-1:0];
            REG_DUTY_MAX:      duty_max_in    = csr_pwdata[DUTY_W-1:0];
            REG_ATTITUDE_SPAN: span_in        = csr_pwdata[SPAN_W-1:0];
            REG_AVOID_YAW:     avoid_yaw_in   = csr_pwdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   // throttle span split as quot*4095 + rem, kept as magnitude and sign
   always_comb begin
      thr_neg_in   = duty_min_in > duty_max_in;
      diff_abs     = thr_neg_in ? (duty_min_in - duty_max_in) : (duty_max_in - duty_min_in);
      quot_full    = div4095({8'd0, diff_abs});
      thr_quot_in  = quot_full[4:0];
      thr_rem_in   = 12'(diff_abs - 16'(thr_quot_in) * 16'(STICK_FULL));
      thresh_us_in = 15'(obstacle_cm_in) * 15'(US_PER_CM);
      far_hit_in   = NO_ECHO_CM < obstacle_cm_in;
   end

   always_ff @(posedge clock) begin
      obstacle_cm_ff <= obstacle_cm_in;
      duty_min_ff    <= duty_min_in;
      duty_max_ff    <= duty_max_in;
      span_ff        <= span_in;
      avoid_yaw_ff   <= avoid_yaw_in;
      thr_quot_ff    <= thr_quot_in;
      thr_rem_ff     <= thr_rem_in;
      thr_neg_ff     <= thr_neg_in;
      thresh_us_ff   <= thresh_us_in;
      far_hit_ff     <= far_hit_in;
   end

   always_comb begin
      case (idx)
         REG_OBSTACLE_CM:   csr_prdata = CSR_DATA_W'(obstacle_cm_ff);
         REG_DUTY_MIN:      csr_prdata = CSR_DATA_W'(duty_min_ff);
         REG_DUTY_MAX:      csr_prdata = CSR_DATA_W'(duty_max_ff);
         REG_ATTITUDE_SPAN: csr_prdata = CSR_DATA_W'(span_ff);
         REG_AVOID_YAW:     csr_prdata = CSR_DATA_W'(avoid_yaw_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.obstacle_cm   = obstacle_cm_ff;
   assign cfg.duty_min      = duty_min_ff;
   assign cfg.duty_max      = duty_max_ff;
   assign cfg.attitude_span = span_ff;
   assign cfg.avoid_yaw     = avoid_yaw_ff;
   assign cfg.thr_quot      = thr_quot_ff;
   assign cfg.thr_rem       = thr_rem_ff;
   assign cfg.thr_neg       = thr_neg_ff;
   assign cfg.thresh_us     = thresh_us_ff;
   assign cfg.far_hit       = far_hit_ff;

endmodule

// ===== rtl/qmix_scale.sv =====
// first stage: stick products and obstacle detection, registered
module qmix_scale
   import qmix_pkg::*;
#(
   parameter logic [15:0] ECHO_TIMEOUT_US = ECHO_TIMEOUT_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_word,
   output logic     s1_valid,
   input  logic     s1_ready,
   output prod_type s1_word
);

   logic     valid_ff, valid_in;
   prod_type word_ff, word_in;
   logic     take;
   logic [10:0] span2;

   function automatic logic echo_hit(input logic [ECHO_W-1:0] w, input cfg_type c);
      logic seen;
      seen = (w != '0) && ({1'b0, w} <= ECHO_TIMEOUT_US);
      return seen ? (w < c.thresh_us) : c.far_hit;
   endfunction

   assign in_ready = !valid_ff || s1_ready;
   assign take     = in_valid && in_ready;
   assign span2    = {cfg.attitude_span, 1'b0};

   always_comb begin
      word_in            = word_ff;
      valid_in           = valid_ff;
      if (take) begin
         valid_in           = 1'b1;
         word_in.roll_prod  = 23'(in_word.stick_roll) * 23'(span2);
         word_in.pitch_prod = 23'(in_word.stick_pitch) * 23'(span2);
         word_in.yaw_prod   = 23'(in_word.stick_yaw) * 23'(span2);
         word_in.thr_hi     = 17'(in_word.stick_throttle) * 17'(cfg.thr_quot);
         word_in.thr_lo     = 24'(in_word.stick_throttle) * 24'(cfg.thr_rem);
         word_in.mask[MASK_FRONT] = echo_hit(in_word.echo_front_us, cfg);
         word_in.mask[MASK_LEFT]  = echo_hit(in_word.echo_left_us, cfg);
         word_in.mask[MASK_RIGHT] = echo_hit(in_word.echo_right_us, cfg);
      end else if (s1_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign s1_valid = valid_ff;
   assign s1_word  = word_ff;

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff)
      else $error("accepted word not held in first stage");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !s1_ready |=> valid_ff && $stable(word_ff))
      else $error("first stage word lost while result side stalled");

endmodule

// ===== rtl/qmix_mix.sv =====
// second stage: divide, override, x-mix and clamp into the result register
module qmix_mix
   import qmix_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     s1_valid,
   output logic     s1_ready,
   input  prod_type s1_word,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_word
);

   logic    valid_ff, valid_in;
   rsp_type word_ff, word_in;
   logic    load;

   logic signed [12:0] span_s, ayaw_s;
   logic signed [12:0] roll_s, pitch_s, yaw_s;
   logic [17:0]        mag;
   logic signed [18:0] thr_s;
   logic signed [19:0] thr_w, roll_w, pitch_w, yaw_w;
   logic signed [19:0] sum0, sum1, sum2, sum3;

   function automatic logic signed [12:0] att(input logic [22:0] p,
                                              input logic signed [12:0] span);
      return $signed({1'b0, div4095({1'b0, p})}) - span;
   endfunction

   function automatic logic [DUTY_W-1:0] clamp(input logic signed [19:0] v,
                                                input logic [DUTY_W-1:0] lo,
                                                input logic [DUTY_W-1:0] hi);
      logic [DUTY_W-1:0] r;
      if (v < $signed({4'd0, lo})) begin
         r = lo;
      end else if (v > $signed({4'd0, hi})) begin
         r = hi;
      end else begin
         r = v[DUTY_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      span_s  = $signed({3'd0, cfg.attitude_span});
      ayaw_s  = $signed({3'd0, cfg.avoid_yaw});
      roll_s  = att(s1_word.roll_prod, span_s);
      pitch_s = att(s1_word.pitch_prod, span_s);
      yaw_s   = att(s1_word.yaw_prod, span_s);
      if (s1_word.mask != '0) begin
         roll_s  = '0;
         pitch_s = '0;
      end
      if (s1_word.mask[MASK_RIGHT]) begin
         yaw_s = ayaw_s;
      end else if (s1_word.mask[MASK_LEFT]) begin
         yaw_s = -ayaw_s;
      end

      mag = 18'(s1_word.thr_hi) + 18'(div4095(s1_word.thr_lo));
      if (s1_word.mask[MASK_FRONT]) begin
         thr_s = $signed({3'd0, cfg.duty_min});
      end else if (cfg.thr_neg) begin
         thr_s = $signed({3'd0, cfg.duty_min}) - $signed({1'b0, mag});
      end else begin
         thr_s = $signed({3'd0, cfg.duty_min}) + $signed({1'b0, mag});
      end

      thr_w   = 20'(thr_s);
      roll_w  = 20'(roll_s);
      pitch_w = 20'(pitch_s);
      yaw_w   = 20'(yaw_s);
      sum0    = thr_w + yaw_w + pitch_w + roll_w;
      sum1    = thr_w - yaw_w + pitch_w - roll_w;
      sum2    = thr_w - yaw_w - pitch_w + roll_w;
      sum3    = thr_w + yaw_w - pitch_w - roll_w;
   end

   assign s1_ready = !valid_ff || out_ready;
   assign load     = s1_valid && s1_ready;

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in              = 1'b1;
         word_in.duty_motor0   = clamp(sum0, cfg.duty_min, cfg.duty_max);
         word_in.duty_motor1   = clamp(sum1, cfg.duty_min, cfg.duty_max);
         word_in.duty_motor2   = clamp(sum2, cfg.duty_min, cfg.duty_max);
         word_in.duty_motor3   = clamp(sum3, cfg.duty_min, cfg.duty_max);
         word_in.override_mask = s1_word.mask;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded word missing from result register");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !s1_valid && s1_ready |=> !valid_ff)
      else $error("result word appeared without a first stage word");

   a_mask_follows: assert property (@(posedge clock) disable iff (reset)
      load |=> word_ff.override_mask == $past(s1_word.mask))
      else $error("override mask not carried into result");

endmodule

// ===== rtl/quad_mixer_with_obstacle_override.sv =====
// top level of the quad x-frame motor mixer with obstacle override
//
//   group   dir  handshake          payload
//   req_    in   tvalid/tready      96-bit tdata: sticks and echo widths
//   rsp_    out  tvalid/tready      72-bit tdata: four duties and override mask
//   csr_    in   psel/penable       apb-style, 5 registers at 4*i, pready tied high
//
// two register stages: products and obstacle checks, then divide, mix and clamp
// one word accepted per cycle while rsp_tready is high; each result passes the first-stage and result registers
// an empty stage fills even while the stage after it is stalled; rsp_tready low fills both, then req_tready drops
// synchronous reset empties both stages and loads register defaults
module quad_mixer_with_obstacle_override
   import qmix_pkg::*;
#(
   parameter logic [15:0] ECHO_TIMEOUT_US = ECHO_TIMEOUT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // roll[11:0] pitch[23:12] throttle[35:24] yaw[47:36]
   // front[62:48] left[77:63] right[92:78] zero[95:93]
   input  logic [95:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor0[15:0] motor1[31:16] motor2[47:32] motor3[63:48] mask[66:64] zero[71:67]
   output logic [71:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   req_type  req_word;
   prod_type s1_word;
   rsp_type  rsp_word;
   logic     s1_valid;
   logic     s1_ready;

   assign req_word = req_type'(req_tdata[$bits(req_type)-1:0]);

   qmix_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qmix_scale #(
      .ECHO_TIMEOUT_US (ECHO_TIMEOUT_US)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_word  (req_word),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_word  (s1_word)
   );

   qmix_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_word   (s1_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   assign rsp_tdata = {5'd0, rsp_word};

endmodule

// ===== test/duty_checker.sv =====
// checker for the quad mixer: tracks registers, predicts motor duties and compares results
`timescale 1ns / 1ps

module duty_checker
   import qmix_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // roll[11:0] pitch[23:12] throttle[35:24] yaw[47:36]
   // front[62:48] left[77:63] right[92:78] zero[95:93]
   input  logic [95:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor0[15:0] motor1[31:16] motor2[47:32] motor3[63:48] mask[66:64] zero[71:67]
   input  logic [71:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    pending,
   output int                    fail_count,
   output int                    checked
);

   localparam longint ECHO_LIMIT = longint'(ECHO_TIMEOUT_DEFAULT);

   logic [CM_W-1:0]   obstacle_q;
   logic [DUTY_W-1:0] duty_min_q;
   logic [DUTY_W-1:0] duty_max_q;
   logic [SPAN_W-1:0] span_q;
   logic [SPAN_W-1:0] avoid_q;

   rsp_type duty_q[$];

   function automatic longint scale_stick(input logic [STICK_W-1:0] raw);
      longint x;
      longint s;
      x = longint'(raw);
      s = longint'(span_q);
      return (x * 2 * s) / longint'(STICK_FULL) - s;
   endfunction

   function automatic longint echo_to_cm(input logic [ECHO_W-1:0] w);
      if (w == '0 || longint'(w) > ECHO_LIMIT) return longint'(NO_ECHO_CM);
      return longint'(w) / longint'(US_PER_CM);
   endfunction

   function automatic logic [DUTY_W-1:0] clamp_duty(input longint v);
      longint lo;
      longint hi;
      lo = longint'(duty_min_q);
      hi = longint'(duty_max_q);
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      return DUTY_W'(v);
   endfunction

   function automatic rsp_type mix_duties(input req_type w);
      longint roll;
      longint pitch;
      longint yaw;
      longint thr;
      longint thresh;
      logic [MASK_W-1:0] mask;
      rsp_type r;
      roll   = scale_stick(w.stick_roll);
      pitch  = scale_stick(w.stick_pitch);
      yaw    = scale_stick(w.stick_yaw);
      thr    = (longint'(w.stick_throttle) * (longint'(duty_max_q) - longint'(duty_min_q)))
               / longint'(STICK_FULL) + longint'(duty_min_q);
      thresh = longint'(obstacle_q);
      mask   = '0;
      if (echo_to_cm(w.echo_front_us) < thresh) begin
         thr = longint'(duty_min_q);
         mask[MASK_FRONT] = 1'b1;
      end
      if (echo_to_cm(w.echo_left_us) < thresh) begin
         yaw = -longint'(avoid_q);
         mask[MASK_LEFT] = 1'b1;
      end
      // right side wins over left
      if (echo_to_cm(w.echo_right_us) < thresh) begin
         yaw = longint'(avoid_q);
         mask[MASK_RIGHT] = 1'b1;
      end
      if (mask != '0) begin
         roll  = 0;
         pitch = 0;
      end
      r.duty_motor0   = clamp_duty(thr + yaw + pitch + roll);
      r.duty_motor1   = clamp_duty(thr - yaw + pitch - roll);
      r.duty_motor2   = clamp_duty(thr - yaw - pitch + roll);
      r.duty_motor3   = clamp_duty(thr + yaw - pitch - roll);
      r.override_mask = mask;
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(input reg_idx_type idx);
      case (idx)
         REG_OBSTACLE_CM:   return CSR_DATA_W'(obstacle_q);
         REG_DUTY_MIN:      return CSR_DATA_W'(duty_min_q);
         REG_DUTY_MAX:      return CSR_DATA_W'(duty_max_q);
         REG_ATTITUDE_SPAN: return CSR_DATA_W'(span_q);
         default:           return CSR_DATA_W'(avoid_q);
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      reg_idx_type idx;
      idx = reg_idx_type'(csr_paddr[4:2]);
      if (reset) begin
         obstacle_q = OBSTACLE_CM_RST;
         duty_min_q = DUTY_MIN_RST;
         duty_max_q = DUTY_MAX_RST;
         span_q     = ATTITUDE_SPAN_RST;
         avoid_q    = AVOID_YAW_RST;
         duty_q.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_pwrite) begin
               case (idx)
                  REG_OBSTACLE_CM:   obstacle_q = csr_pwdata[CM_W-1:0];
                  REG_DUTY_MIN:      duty_min_q = csr_pwdata[DUTY_W-1:0];
                  REG_DUTY_MAX:      duty_max_q = csr_pwdata[DUTY_W-1:0];
                  REG_ATTITUDE_SPAN: span_q     = csr_pwdata[SPAN_W-1:0];
                  REG_AVOID_YAW:     avoid_q    = csr_pwdata[SPAN_W-1:0];
                  default: ;
               endcase
            end else if (csr_paddr[4:2] <= REG_AVOID_YAW) begin
               check_field("csr_prdata", int'(reg_value(idx)), int'(csr_prdata));
            end
         end
         if (req_tvalid && req_tready) duty_q.push_back(mix_duties(req_type'(req_tdata[92:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[66:0]);
            if (duty_q.size() == 0) begin
               $error("result word with no prediction pending");
               fail_count++;
            end else begin
               want = duty_q.pop_front();
               check_field("duty_motor0", int'(want.duty_motor0), int'(got.duty_motor0));
               check_field("duty_motor1", int'(want.duty_motor1), int'(got.duty_motor1));
               check_field("duty_motor2", int'(want.duty_motor2), int'(got.duty_motor2));
               check_field("duty_motor3", int'(want.duty_motor3), int'(got.duty_motor3));
               check_field("override_mask", int'(want.override_mask),
                           int'(got.override_mask));
            end
            checked++;
         end
      end
      pending = duty_q.size();
   end

endmodule

// ===== test/tb.sv =====
// testbench top for the quad mixer: clock, reset, stimulus, register settings and verdict
`timescale 1ns / 1ps

module tb;
   import qmix_pkg::*;

   localparam int RUN_ITEMS   = 68;
   localparam int HOLD_CYCLES = 60;
   localparam int SPARE_IDX   = 5;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [95:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [71:0]           rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int pending;
   int fail_count;
   int checked;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cur_obstacle = int'(OBSTACLE_CM_RST);
   int settings_loaded = 0;

   always #5 clock = ~clock;

   quad_mixer_with_obstacle_override dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   duty_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .fail_count  (fail_count),
      .checked     (checked)
   );

   // receiver: random stalls, or a long hold-off counted here
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_left = HOLD_CYCLES;
         hold_seen = hold_req;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic write_reg(input int idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_reg(input int idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_all_regs();
      for (int i = REG_OBSTACLE_CM; i <= REG_AVOID_YAW; i++) read_reg(i);
   endtask

   // sender stops and waits until every predicted word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic offer_sample(input req_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type mk_sample(input int roll, input int pitch, input int thr,
                                         input int yaw, input int front, input int left,
                                         input int right);
      req_type w;
      w.stick_roll     = STICK_W'(roll);
      w.stick_pitch    = STICK_W'(pitch);
      w.stick_throttle = STICK_W'(thr);
      w.stick_yaw      = STICK_W'(yaw);
      w.echo_front_us  = ECHO_W'(front);
      w.echo_left_us   = ECHO_W'(left);
      w.echo_right_us  = ECHO_W'(right);
      return w;
   endfunction

   function automatic int rand_stick();
      case ($urandom_range(5))
         0:       return 0;
         1:       return 4095;
         default: return int'($urandom_range(4095));
      endcase
   endfunction

   function automatic int rand_echo();
      int near;
      case ($urandom_range(7))
         0: return 0;
         1: return int'($urandom_range(32767, 30001));
         2: return int'(ECHO_TIMEOUT_DEFAULT);
         3, 4: begin
            near = cur_obstacle * int'(US_PER_CM) + int'($urandom_range(115)) - 58;
            return (near < 0) ? 0 : near;
         end
         5: return int'($urandom_range(57, 1));
         default: return int'($urandom_range(32767));
      endcase
   endfunction

   task automatic load_setting(input int k);
      logic [CSR_DATA_W-1:0] vals [5];
      logic [CSR_DATA_W-1:0] level;
      drain();
      case (k)
         0: vals = '{OBSTACLE_CM_RST, DUTY_MIN_RST, DUTY_MAX_RST, ATTITUDE_SPAN_RST,
                     AVOID_YAW_RST};
         1: vals = '{300, 0, 65535, 1000, 1000};
         2: vals = '{1, 65535, 0, 0, 0};
         3: vals = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         default: begin
            level = $urandom_range(65535);
            vals = '{511, level, level, 1023, 1023};
         end
      endcase
      for (int i = REG_OBSTACLE_CM; i <= REG_AVOID_YAW; i++) write_reg(i, vals[i]);
      write_reg(SPARE_IDX + int'($urandom_range(2)), $urandom());
      cur_obstacle = int'(vals[REG_OBSTACLE_CM][CM_W-1:0]);
      settings_loaded++;
      read_all_regs();
   endtask

   initial begin
      int tx_mix [3] = '{30, 78, 0};
      int rx_mix [3] = '{78, 30, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      read_all_regs();

      // reset settings: extremes, echo timeout edges, each obstacle rule
      offer_sample(mk_sample(0, 0, 0, 0, 0, 0, 0));
      offer_sample(mk_sample(4095, 4095, 4095, 4095, 0, 0, 0));
      offer_sample(mk_sample(2048, 2048, 2048, 2048, 30000, 30000, 30000));
      offer_sample(mk_sample(4095, 0, 4095, 0, 30001, 32767, 30001));
      offer_sample(mk_sample(4095, 4095, 4095, 4095, 32767, 32767, 32767));
      offer_sample(mk_sample(1000, 3000, 2000, 500, 1739, 0, 0));
      offer_sample(mk_sample(1000, 3000, 2000, 500, 1740, 0, 0));
      offer_sample(mk_sample(3000, 1000, 2500, 4000, 0, 57, 0));
      offer_sample(mk_sample(3000, 1000, 2500, 4000, 0, 0, 1000));
      offer_sample(mk_sample(200, 3900, 3500, 100, 0, 100, 100));
      offer_sample(mk_sample(4095, 4095, 4095, 4095, 1, 1, 1));
      offer_sample(mk_sample(4095, 4095, 4095, 4095, 500, 0, 0));
      offer_sample(mk_sample(0, 4095, 0, 4095, 0, 1739, 0));
      offer_sample(mk_sample(0, 4095, 0, 4095, 0, 1740, 1741));

      // inverted duty range with zero span
      load_setting(2);
      offer_sample(mk_sample(0, 0, 0, 0, 0, 0, 0));
      offer_sample(mk_sample(4095, 4095, 4095, 4095, 0, 0, 0));
      offer_sample(mk_sample(2048, 2048, 2048, 2048, 0, 0, 0));
      offer_sample(mk_sample(100, 4000, 3000, 2000, 0, 0, 500));

      for (int p = 0; p < 3; p++) begin
         for (int k = 0; k < 5; k++) begin
            load_setting(k);
            tx_idle_pct = tx_mix[p];
            rx_idle_pct = rx_mix[p];
            for (int n = 0; n < RUN_ITEMS; n++) begin
               if (n == RUN_ITEMS / 2) drain();
               if (p == 2 && k < 2 && n == 10) hold_req++;
               offer_sample(mk_sample(rand_stick(), rand_stick(), rand_stick(), rand_stick(),
                                      rand_echo(), rand_echo(), rand_echo()));
            end
         end
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      for (int guard = 0; pending != 0 && guard < 20000; guard++) @(negedge clock);
      repeat (20) @(negedge clock);
      if (pending != 0) $error("%0d predicted words never arrived", pending);

      $display("checked %0d result words over %0d register settings", checked, settings_loaded);
      $display("three sender/receiver idle mixes, two receiver hold-offs, mid-run drains");
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
